// ----- sv/pid_rate_axis_with_d_filter_assert.svh -----
// Assertion helpers used by the top-level RTL file.
`ifndef PID_RATE_AXIS_WITH_D_FILTER_ASSERT_SVH
`define PID_RATE_AXIS_WITH_D_FILTER_ASSERT_SVH

// Plain property, checked on every rising edge outside reset.
`define PIDR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define PIDR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/pidr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pidr_pkg;

  localparam int GAIN_W      = 24;
  localparam int COEFF_W     = 17;
  localparam int LIMIT_W     = 15;
  localparam int CFG_DATA_W  = 24;
  localparam int CFG_IDX_W   = 3;
  localparam int FILT_W      = 32;
  localparam int SMOOTH_FRAC = 16;
  localparam int DIGIT_W     = 4;

  localparam logic [COEFF_W-1:0] COEFF_ONE = 17'h10000;
  localparam logic [LIMIT_W-1:0] LIMIT_RST = 15'd6400;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_SMOOTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT = 3'd4;

  typedef struct packed {
    logic [GAIN_W-1:0]  prop_gain;
    logic [GAIN_W-1:0]  integ_gain;
    logic [GAIN_W-1:0]  deriv_gain;
    logic [COEFF_W-1:0] coeff;
    logic [LIMIT_W-1:0] limit;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_sts_t;

endpackage

`default_nettype wire

// ----- sv/pid_rate_axis_with_d_filter.sv -----
// One axis of a rate PID controller with clamped integral and a low-pass
// filtered derivative on the measurement.
// Input channel: in_valid_i / in_stall_o with measured_rate_i, target_rate_i
// and clear_state_i. Output channel: out_valid_o / out_stall_i with drive_o.
// A transaction moves on a rising edge with valid high and stall low.
// Gains, smoothing and limit are written through cfg_we_i / cfg_idx_i /
// cfg_data_i; the user must write them only while the block is idle, which
// the block itself does not enforce. For a normal item, four products run
// through one shared multiplier that consumes 4 multiplier bits per cycle,
// with the add, clamp and saturate steps between them.
// One item is in flight at a time; the next can be taken in the cycle after
// the result is registered.
// A clear item zeroes the loop state and goes straight to S_OUT, which
// registers drive 0.
// A stalled result holds in the output register; the next item is accepted
// meanwhile and its result waits until the previous one is taken.
// Reset clears the loop state, the handshake and the registers to defaults.
`timescale 1ns / 1ps
`default_nettype none
`include "pid_rate_axis_with_d_filter_assert.svh"

module pid_rate_axis_with_d_filter #(
  parameter int DATA_WIDTH     = 16,
  parameter int GAIN_FRAC_BITS = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  in_valid_i,
  output logic                                       in_stall_o,
  input  wire logic signed [DATA_WIDTH-1:0]          measured_rate_i,
  input  wire logic signed [DATA_WIDTH-1:0]          target_rate_i,
  input  wire logic                                  clear_state_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_stall_i,
  output logic signed [DATA_WIDTH-1:0]               drive_o,
  input  wire logic                                  cfg_we_i,
  input  wire logic [pidr_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire logic [pidr_pkg::CFG_DATA_W-1:0]       cfg_data_i
);

  localparam int FW      = pidr_pkg::FILT_W;
  localparam int ERR_W   = DATA_WIDTH + 1;
  localparam int MCAND_W = ((DATA_WIDTH > FW) ? DATA_WIDTH : FW) + 2;
  localparam int PROD_W  = MCAND_W + pidr_pkg::DIGIT_W + pidr_pkg::GAIN_W + 1;

  localparam logic signed [PROD_W-1:0] FILT_MAX = PROD_W'({1'b0, {(FW - 1){1'b1}}});
  localparam logic signed [PROD_W-1:0] FILT_MIN = ~FILT_MAX;

  typedef enum logic [3:0] {
    S_IDLE, S_INT_MUL, S_INT_ADD, S_INT_CLAMP, S_DIFF, S_FILT_MUL, S_FILT_ADD,
    S_FILT_SAT, S_PROP_MUL, S_PROP_ADD, S_DER_MUL, S_DER_ADD, S_OUT_CLAMP, S_OUT
  } state_e;

  pidr_pkg::cfg_t     cfg;
  pidr_pkg::mul_sts_t mul_sts;

  state_e                         state_q;
  logic                           start_q, out_valid_q;
  logic signed [DATA_WIDTH-1:0]   integ_q, prev_q, drive_q;
  logic signed [FW-1:0]           filt_q;
  logic signed [ERR_W-1:0]        err_q, raw_q;
  logic signed [MCAND_W-1:0]      diff_q;
  logic signed [PROD_W-1:0]       sum_q;

  logic signed [ERR_W-1:0]        err_d, raw_d;
  logic signed [MCAND_W-1:0]      mul_mcand;
  logic [pidr_pkg::GAIN_W-1:0]    mul_mplier;
  logic signed [PROD_W-1:0]       prod, res_gain, res_smooth, lim_s, clamp_val;
  logic                           in_mul, in_acc;

  pidr_cfg #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  pidr_mul #(
    .MCAND_W(MCAND_W)
  ) u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_q),
    .mcand_i  (mul_mcand),
    .mplier_i (mul_mplier),
    .sts_o    (mul_sts),
    .prod_o   (prod)
  );

  always_comb begin
    in_acc = in_valid_i && (state_q == S_IDLE);
    err_d  = ERR_W'(measured_rate_i) - ERR_W'(target_rate_i);
    raw_d  = ERR_W'(prev_q) - ERR_W'(measured_rate_i);
    in_mul = (state_q == S_INT_MUL) || (state_q == S_FILT_MUL) ||
             (state_q == S_PROP_MUL) || (state_q == S_DER_MUL);

    unique case (state_q)
      S_INT_MUL: begin
        mul_mcand  = MCAND_W'(err_q);
        mul_mplier = cfg.integ_gain;
      end
      S_FILT_MUL: begin
        mul_mcand  = diff_q;
        mul_mplier = pidr_pkg::GAIN_W'(cfg.coeff);
      end
      S_PROP_MUL: begin
        mul_mcand  = MCAND_W'(err_q);
        mul_mplier = cfg.prop_gain;
      end
      S_DER_MUL: begin
        mul_mcand  = MCAND_W'(filt_q);
        mul_mplier = cfg.deriv_gain;
      end
      default: begin
        mul_mcand  = '0;
        mul_mplier = '0;
      end
    endcase

    res_gain   = prod >>> GAIN_FRAC_BITS;
    res_smooth = prod >>> pidr_pkg::SMOOTH_FRAC;
    lim_s      = PROD_W'({1'b0, cfg.limit});
    if (sum_q > lim_s) begin
      clamp_val = lim_s;
    end else if (sum_q < -lim_s) begin
      clamp_val = -lim_s;
    end else begin
      clamp_val = sum_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
      integ_q     <= '0;
      prev_q      <= '0;
      filt_q      <= '0;
      drive_q     <= '0;
      err_q       <= '0;
      raw_q       <= '0;
      diff_q      <= '0;
      sum_q       <= '0;
    end else begin
      start_q <= 1'b0;
      if (out_valid_q && !out_stall_i && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (clear_state_i) begin
              integ_q <= '0;
              prev_q  <= '0;
              filt_q  <= '0;
              sum_q   <= '0;
              state_q <= S_OUT;
            end else begin
              err_q   <= err_d;
              raw_q   <= raw_d;
              prev_q  <= measured_rate_i;
              start_q <= 1'b1;
              state_q <= S_INT_MUL;
            end
          end
        end
        S_INT_MUL: begin
          if (mul_sts.done) state_q <= S_INT_ADD;
        end
        S_INT_ADD: begin
          sum_q   <= PROD_W'(integ_q) + res_gain;
          state_q <= S_INT_CLAMP;
        end
        S_INT_CLAMP: begin
          integ_q <= clamp_val[DATA_WIDTH-1:0];
          state_q <= S_DIFF;
        end
        S_DIFF: begin
          diff_q  <= MCAND_W'(raw_q) - MCAND_W'(filt_q);
          start_q <= 1'b1;
          state_q <= S_FILT_MUL;
        end
        S_FILT_MUL: begin
          if (mul_sts.done) state_q <= S_FILT_ADD;
        end
        S_FILT_ADD: begin
          sum_q   <= PROD_W'(filt_q) + res_smooth;
          state_q <= S_FILT_SAT;
        end
        S_FILT_SAT: begin
          if (sum_q > FILT_MAX) begin
            filt_q <= FILT_MAX[FW-1:0];
          end else if (sum_q < FILT_MIN) begin
            filt_q <= FILT_MIN[FW-1:0];
          end else begin
            filt_q <= sum_q[FW-1:0];
          end
          start_q <= 1'b1;
          state_q <= S_PROP_MUL;
        end
        S_PROP_MUL: begin
          if (mul_sts.done) state_q <= S_PROP_ADD;
        end
        S_PROP_ADD: begin
          sum_q   <= PROD_W'(integ_q) + res_gain;
          start_q <= 1'b1;
          state_q <= S_DER_MUL;
        end
        S_DER_MUL: begin
          if (mul_sts.done) state_q <= S_DER_ADD;
        end
        S_DER_ADD: begin
          sum_q   <= sum_q + res_gain;
          state_q <= S_OUT_CLAMP;
        end
        S_OUT_CLAMP: begin
          sum_q   <= clamp_val;
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_q || !out_stall_i) begin
            drive_q     <= sum_q[DATA_WIDTH-1:0];
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_q;

  `PIDR_ASSERT(a_mul_busy_in_seq, clk_i, rst_ni, mul_sts.busy |-> in_mul, "mul busy when idle")
  `PIDR_ASSERT(a_mul_done_in_seq, clk_i, rst_ni, mul_sts.done |-> in_mul, "mul done when idle")
  `PIDR_ASSERT_NEXT(a_accept_starts, clk_i, rst_ni, in_acc, state_q != S_IDLE, "idle after accept")
  `PIDR_ASSERT_NEXT(a_rise_src, clk_i, rst_ni, state_q != S_OUT, !$rose(out_valid_o), "bad rise")

endmodule

`default_nettype wire

// ----- sv/pidr_cfg.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pidr_cfg #(
  parameter int DATA_WIDTH = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [pidr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [pidr_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output pidr_pkg::cfg_t                        cfg_o
);

  localparam int unsigned LIM_CAP = (DATA_WIDTH - 1 < pidr_pkg::LIMIT_W) ?
      ((32'd1 << (DATA_WIDTH - 1)) - 32'd1) : ((32'd1 << pidr_pkg::LIMIT_W) - 32'd1);
  localparam logic [pidr_pkg::LIMIT_W-1:0] LIM_MAX = pidr_pkg::LIMIT_W'(LIM_CAP);

  logic [pidr_pkg::GAIN_W-1:0]  prop_q, integ_q, deriv_q;
  logic [pidr_pkg::COEFF_W-1:0] coeff_q;
  logic [pidr_pkg::LIMIT_W-1:0] limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_q  <= '0;
      integ_q <= '0;
      deriv_q <= '0;
      coeff_q <= pidr_pkg::COEFF_ONE;
      limit_q <= pidr_pkg::LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pidr_pkg::REG_PROP_GAIN:    prop_q  <= cfg_data_i;
        pidr_pkg::REG_INTEG_GAIN:   integ_q <= cfg_data_i;
        pidr_pkg::REG_DERIV_GAIN:   deriv_q <= cfg_data_i;
        pidr_pkg::REG_DERIV_SMOOTH: coeff_q <= cfg_data_i[pidr_pkg::COEFF_W-1:0];
        pidr_pkg::REG_DRIVE_LIMIT:  limit_q <= cfg_data_i[pidr_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_o.prop_gain  = prop_q;
    cfg_o.integ_gain = integ_q;
    cfg_o.deriv_gain = deriv_q;
    cfg_o.coeff      = (coeff_q > pidr_pkg::COEFF_ONE) ? pidr_pkg::COEFF_ONE : coeff_q;
    cfg_o.limit      = (limit_q > LIM_MAX) ? LIM_MAX : limit_q;
  end

endmodule

`default_nettype wire

// ----- sv/pidr_mul.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Digit-serial signed x unsigned multiplier, one multiplier digit per cycle.
module pidr_mul #(
  parameter int MCAND_W = 34
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  start_i,
  input  wire logic signed [MCAND_W-1:0]             mcand_i,
  input  wire logic        [pidr_pkg::GAIN_W-1:0]    mplier_i,
  output pidr_pkg::mul_sts_t                         sts_o,
  output logic signed [MCAND_W+pidr_pkg::DIGIT_W+pidr_pkg::GAIN_W:0] prod_o
);

  localparam int DW    = pidr_pkg::DIGIT_W;
  localparam int MW    = pidr_pkg::GAIN_W;
  localparam int STEPS = MW / DW;
  localparam int CNT_W = $clog2(STEPS);
  localparam int HI_W  = MCAND_W + DW + 1;

  logic signed [MCAND_W-1:0] mcand_q;
  logic signed [HI_W-1:0]    hi_q;
  logic        [MW-1:0]      lo_q;
  logic        [CNT_W-1:0]   cnt_q;
  logic                      busy_q, done_q;

  logic signed [HI_W-1:0] partial, sum;

  always_comb begin
    partial = HI_W'(mcand_q) * HI_W'($signed({1'b0, lo_q[DW-1:0]}));
    sum     = hi_q + partial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mcand_q <= '0;
      hi_q    <= '0;
      lo_q    <= '0;
      cnt_q   <= '0;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        mcand_q <= mcand_i;
        hi_q    <= '0;
        lo_q    <= mplier_i;
        cnt_q   <= '0;
        busy_q  <= 1'b1;
      end else if (busy_q) begin
        hi_q  <= sum >>> DW;
        lo_q  <= {sum[DW-1:0], lo_q[MW-1:DW]};
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign prod_o     = {hi_q, lo_q};

endmodule

`default_nettype wire

// ----- bench/pid_drive_checker.sv -----
`timescale 1ns / 1ps

module pid_drive_checker #(
  parameter int DATA_W    = 16,
  parameter int GAIN_FRAC = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic                               in_stall_i,
  input  logic signed [DATA_W-1:0]           measured_rate_i,
  input  logic signed [DATA_W-1:0]           target_rate_i,
  input  logic                               clear_state_i,
  input  logic                               out_valid_i,
  input  logic                               out_stall_i,
  input  logic signed [DATA_W-1:0]           drive_i,
  input  logic                               cfg_we_i,
  input  logic [pidr_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [pidr_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output int                                 mismatch_count_o,
  output int                                 pending_o
);

  localparam longint DRIVE_MAX = (longint'(1) <<< (DATA_W - 1)) - 1;
  localparam longint FILT_MAX  = (longint'(1) <<< (pidr_pkg::FILT_W - 1)) - 1;
  localparam longint FILT_MIN  = -FILT_MAX - 1;

  logic [pidr_pkg::GAIN_W-1:0]  prop_gain;
  logic [pidr_pkg::GAIN_W-1:0]  integ_gain;
  logic [pidr_pkg::GAIN_W-1:0]  deriv_gain;
  logic [pidr_pkg::COEFF_W-1:0] smoothing;
  logic [pidr_pkg::LIMIT_W-1:0] drive_limit;

  longint integ_acc;
  longint last_meas;
  longint filt_acc;

  logic signed [DATA_W-1:0] expected_drive[$];
  int mismatches = 0;

  function automatic longint clamp_sym(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic logic signed [DATA_W-1:0] next_drive(
    input logic signed [DATA_W-1:0] meas,
    input logic signed [DATA_W-1:0] targ,
    input logic                     clr
  );
    longint lim, err, raw, coeff, filt, total;
    lim = longint'(drive_limit);
    if (lim > DRIVE_MAX) lim = DRIVE_MAX;
    if (clr) begin
      integ_acc = 0;
      last_meas = 0;
      filt_acc  = 0;
      return '0;
    end
    err = longint'(meas) - longint'(targ);
    integ_acc = clamp_sym(integ_acc + ((longint'(integ_gain) * err) >>> GAIN_FRAC), lim);
    raw = last_meas - longint'(meas);
    last_meas = longint'(meas);
    coeff = (smoothing > pidr_pkg::COEFF_ONE) ? longint'(pidr_pkg::COEFF_ONE)
                                              : longint'(smoothing);
    filt = filt_acc + ((coeff * (raw - filt_acc)) >>> pidr_pkg::SMOOTH_FRAC);
    if (filt > FILT_MAX) filt = FILT_MAX;
    if (filt < FILT_MIN) filt = FILT_MIN;
    filt_acc = filt;
    total = ((longint'(prop_gain) * err) >>> GAIN_FRAC) + integ_acc
          + ((longint'(deriv_gain) * filt_acc) >>> GAIN_FRAC);
    total = clamp_sym(total, lim);
    return DATA_W'(total);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [DATA_W-1:0] want;
    if (!rst_ni) begin
      prop_gain   = '0;
      integ_gain  = '0;
      deriv_gain  = '0;
      smoothing   = pidr_pkg::COEFF_ONE;
      drive_limit = pidr_pkg::LIMIT_RST;
      integ_acc   = 0;
      last_meas   = 0;
      filt_acc    = 0;
      expected_drive.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          pidr_pkg::REG_PROP_GAIN:    prop_gain   = cfg_data_i[pidr_pkg::GAIN_W-1:0];
          pidr_pkg::REG_INTEG_GAIN:   integ_gain  = cfg_data_i[pidr_pkg::GAIN_W-1:0];
          pidr_pkg::REG_DERIV_GAIN:   deriv_gain  = cfg_data_i[pidr_pkg::GAIN_W-1:0];
          pidr_pkg::REG_DERIV_SMOOTH: smoothing   = cfg_data_i[pidr_pkg::COEFF_W-1:0];
          pidr_pkg::REG_DRIVE_LIMIT:  drive_limit = cfg_data_i[pidr_pkg::LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_drive.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected drive transaction %0d", $time, drive_i);
        end else begin
          want = expected_drive.pop_front();
          if (drive_i !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: drive expected %0d, got %0d", $time, want, drive_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_drive.push_back(next_drive(measured_rate_i, target_rate_i, clear_state_i));
    end
    mismatch_count_o <= mismatches;
    pending_o <= expected_drive.size();
  end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  localparam int DATA_W      = 16;
  localparam int SETTLE      = 48;
  localparam int HOLD_CYCLES = 400;
  localparam int QUIET_LIMIT = 3000;
  localparam int BLOCKS      = 15;
  localparam int BLOCK_ITEMS = 102;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                               in_valid_i = 1'b0;
  logic                               in_stall_o;
  logic signed [DATA_W-1:0]           measured_rate_i = '0;
  logic signed [DATA_W-1:0]           target_rate_i = '0;
  logic                               clear_state_i = 1'b0;
  logic                               out_valid_o;
  logic                               out_stall_i = 1'b0;
  logic signed [DATA_W-1:0]           drive_o;
  logic                               cfg_we_i = 1'b0;
  logic [pidr_pkg::CFG_IDX_W-1:0]     cfg_idx_i = '0;
  logic [pidr_pkg::CFG_DATA_W-1:0]    cfg_data_i = '0;

  int mismatches;
  int pending;
  int send_idle_pct = 7;
  int recv_idle_pct = 48;
  logic hold_req = 1'b0;
  logic hold_ack = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;

  always #5 clk_i = ~clk_i;

  pid_rate_axis_with_d_filter uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .measured_rate_i(measured_rate_i),
    .target_rate_i  (target_rate_i),
    .clear_state_i  (clear_state_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .drive_o        (drive_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  pid_drive_checker #(.DATA_W(DATA_W), .GAIN_FRAC(16)) drive_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .measured_rate_i (measured_rate_i),
    .target_rate_i   (target_rate_i),
    .clear_state_i   (clear_state_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .drive_i         (drive_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .mismatch_count_o(mismatches),
    .pending_o       (pending)
  );

  // receiver: random stalls, or a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input logic [DATA_W-1:0] meas, input logic [DATA_W-1:0] targ,
                           input logic clr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    measured_rate_i <= meas;
    target_rate_i <= targ;
    clear_state_i <= clr;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic wait_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_config(input logic [pidr_pkg::CFG_DATA_W-1:0] pg,
                              input logic [pidr_pkg::CFG_DATA_W-1:0] ig,
                              input logic [pidr_pkg::CFG_DATA_W-1:0] dg,
                              input logic [pidr_pkg::CFG_DATA_W-1:0] sm,
                              input logic [pidr_pkg::CFG_DATA_W-1:0] lim);
    wait_results();
    repeat (SETTLE) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= pidr_pkg::REG_PROP_GAIN;
    cfg_data_i <= pg;
    @(posedge clk_i);
    cfg_idx_i <= pidr_pkg::REG_INTEG_GAIN;
    cfg_data_i <= ig;
    @(posedge clk_i);
    cfg_idx_i <= pidr_pkg::REG_DERIV_GAIN;
    cfg_data_i <= dg;
    @(posedge clk_i);
    cfg_idx_i <= pidr_pkg::REG_DERIV_SMOOTH;
    cfg_data_i <= sm;
    @(posedge clk_i);
    cfg_idx_i <= pidr_pkg::REG_DRIVE_LIMIT;
    cfg_data_i <= lim;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [pidr_pkg::CFG_DATA_W-1:0] pick_gain();
    case ($urandom_range(5))
      0:       return '0;
      1:       return 24'hFFFFFF;
      2, 3:    return 24'($urandom_range(0, 24'h03FFFF));
      default: return 24'($urandom());
    endcase
  endfunction

  initial begin
    logic [pidr_pkg::CFG_DATA_W-1:0] smooth;
    logic [pidr_pkg::CFG_DATA_W-1:0] lim;
    int rate;
    int set_point;
    int r;
    rate = 0;
    set_point = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: zero gains
    send_item(16'sd100, -16'sd100, 1'b0);
    send_item(16'h8000, 16'h7FFF, 1'b0);

    write_config(24'h010000, 24'h004000, 24'h008000, 24'(pidr_pkg::COEFF_ONE), 24'd6400);
    send_item(16'sd100, 16'sd0, 1'b0);
    send_item(16'sd300, 16'sd0, 1'b0);
    send_item(16'h7FFF, 16'h8000, 1'b0);
    send_item(16'h8000, 16'h7FFF, 1'b0);
    send_item(-16'sd1, -16'sd1, 1'b0);
    send_item(16'sd0, 16'sd0, 1'b0);
    send_item(16'sd5000, -16'sd5000, 1'b1);
    send_item(16'sd0, 16'sd0, 1'b1);
    send_item(-16'sd200, 16'sd100, 1'b0);
    send_item(16'h7FFF, 16'h7FFF, 1'b0);

    // full-scale gains, smoothing coefficient above one
    write_config(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'h01FFFF, 24'd32767);
    send_item(16'sd1, 16'sd0, 1'b0);
    send_item(16'h8000, 16'sd0, 1'b0);
    send_item(16'h7FFF, 16'sd0, 1'b0);
    send_item(16'h8000, 16'h7FFF, 1'b0);
    send_item(16'sd0, 16'sd0, 1'b1);

    // heavy derivative smoothing
    write_config(24'h00C000, 24'h000100, 24'h100000, 24'h000800, 24'd32767);
    send_item(16'sd2000, 16'sd0, 1'b0);
    send_item(-16'sd2000, 16'sd0, 1'b0);
    send_item(16'sd2000, 16'sd0, 1'b0);

    // zero limit pins integral and drive at zero
    write_config(24'hFFFFFF, 24'hFFFFFF, 24'h000000, 24'h000000, 24'd0);
    send_item(16'sd1234, -16'sd4321, 1'b0);
    send_item(16'h8000, 16'h7FFF, 1'b0);
    send_item(16'h7FFF, 16'h8000, 1'b0);

    for (int blk = 0; blk < BLOCKS; blk++) begin
      if (blk == 5) begin
        send_idle_pct <= 48;
        recv_idle_pct <= 7;
      end else if (blk == 10) begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
      end
      case ($urandom_range(3))
        0:       smooth = 24'(pidr_pkg::COEFF_ONE);
        1:       smooth = 24'($urandom_range(0, 65536));
        2:       smooth = 24'($urandom_range(65537, 131071));
        default: smooth = 24'($urandom_range(1, 4096));
      endcase
      case ($urandom_range(9))
        0:       lim = 24'd0;
        1:       lim = 24'd32767;
        default: lim = 24'($urandom_range(100, 32767));
      endcase
      write_config(pick_gain(), pick_gain(), pick_gain(), smooth, lim);
      rate = 0;
      set_point = 0;
      for (int n = 0; n < BLOCK_ITEMS; n++) begin
        if (blk % 5 == 1 && n == 20) hold_req <= ~hold_req;
        if (blk % 5 == 3 && n == 50) wait_results();
        r = $urandom_range(99);
        if (r < 4) begin
          send_item(16'($urandom()), 16'($urandom()), 1'b1);
          rate = 0;
        end else if (r < 14) begin
          send_item(16'($urandom()), 16'($urandom()), 1'b0);
        end else begin
          if ($urandom_range(19) == 0) set_point = int'($urandom_range(0, 8000)) - 4000;
          rate = rate + (set_point - rate) / 8 + int'($urandom_range(0, 200)) - 100;
          if (rate > 32767) rate = 32767;
          if (rate < -32768) rate = -32768;
          send_item(16'(rate), 16'(set_point), 1'b0);
        end
      end
    end

    wait_results();
    repeat (SETTLE) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
